FILE: sv/lgrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared constants, types and the B3/S23 cell rule for the Life row stream.
// ----------------------------------------------------------------------------
package lgrs_pkg;

    localparam int ROW_BITS       = 64;
    localparam int WIDTH_BITS     = 7;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam logic [WIDTH_BITS-1:0] ACTIVE_WIDTH_RST = 7'd64;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Control of the job waiting for the output register
    typedef struct packed {
        logic valid;
        logic pend2;   // a second job (own row of the last row) follows
        logic done;    // job is the grid's final row
    } t_job_ctrl;

    function automatic logic cell_next(input logic self_alive, input logic [7:0] nbrs);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(nbrs[k]);
        end
        return (n == BIRTH_COUNT) || (self_alive && (n == SURVIVE_COUNT));
    endfunction

endpackage

FILE: sv/life_generation_row_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_row_stream_core
// Conway Life (B3/S23) generation over a grid streamed one row per transfer.
// The row transfer that completes a result loads the job register, then the
// output register offers the result.
// Throughput: one row per cycle unless stalled; a last row with a row before
// it stalls, as its two results share the one evolve unit and output register.
// Reset: synchronous, active low; clears job and seen flag; sets width to 64.
// ----------------------------------------------------------------------------
module life_generation_row_stream_core
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [WIDTH_BITS-1:0] i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ROW_BITS-1:0]   i_row_cells,
    input  logic                  i_last_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ROW_BITS-1:0]   o_next_row_cells,
    output logic                  o_grid_done
);

    logic [WIDTH_BITS-1:0] r_active_width;
    logic [MAX_WIDTH-1:0]  mask;
    t_job_ctrl             job;
    logic [MAX_WIDTH-1:0]  j_up, j_mid, j_dn;
    logic [MAX_WIDTH-1:0]  evolved;
    logic                  out_adv;
    logic                  in_xfer;
    logic                  r_o_valid;
    logic [MAX_WIDTH-1:0]  r_o_cells;
    logic                  r_o_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width <= ACTIVE_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            r_active_width <= i_cfg_wr_data;
        end
    end

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
        assign mask[c] = (WIDTH_BITS'(c) < r_active_width);
    end

    assign out_adv    = job.valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = job.valid && !(out_adv && !job.pend2);
    assign in_xfer    = i_in_valid && !o_in_stall;

    lgrs_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_xfer (in_xfer),
        .i_row     (i_row_cells[MAX_WIDTH-1:0]),
        .i_last    (i_last_row),
        .i_mask    (mask),
        .i_adv     (out_adv),
        .o_job     (job),
        .o_up      (j_up),
        .o_mid     (j_mid),
        .o_dn      (j_dn)
    );

    lgrs_evolve #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_evolve (
        .i_up    (j_up),
        .i_mid   (j_mid),
        .i_dn    (j_dn),
        .i_mask  (mask),
        .o_cells (evolved)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
        if (out_adv) begin
            r_o_cells <= evolved;
            r_o_done  <= job.done;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_next_row_cells = ROW_BITS'(r_o_cells);
    assign o_grid_done      = r_o_done;

`ifndef NO_ASSERTIONS
    a_pend2_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job.pend2 |-> job.valid)
        else $error("second job pending without a job");

    a_pend2_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && job.pend2) |=> (job.valid && !job.pend2 && job.done))
        else $error("last row's own result lost");

    a_out_from_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(out_adv))
        else $error("result offered without a job");

    a_done_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job.valid && job.done) |-> !job.pend2)
        else $error("final job still has a follower");
`endif

endmodule

FILE: sv/lgrs_evolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_evolve
// Next generation of one row from its 3-row window, all columns in parallel.
// ----------------------------------------------------------------------------
module lgrs_evolve
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic [MAX_WIDTH-1:0] i_up,
    input  logic [MAX_WIDTH-1:0] i_mid,
    input  logic [MAX_WIDTH-1:0] i_dn,
    input  logic [MAX_WIDTH-1:0] i_mask,
    output logic [MAX_WIDTH-1:0] o_cells
);

    logic [MAX_WIDTH+1:0] pad_up;
    logic [MAX_WIDTH+1:0] pad_mid;
    logic [MAX_WIDTH+1:0] pad_dn;

    // dead column on either side of the row
    assign pad_up  = {1'b0, i_up  & i_mask, 1'b0};
    assign pad_mid = {1'b0, i_mid & i_mask, 1'b0};
    assign pad_dn  = {1'b0, i_dn  & i_mask, 1'b0};

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
        logic [7:0] nbrs;
        assign nbrs = {pad_up[c+2:c], pad_dn[c+2:c], pad_mid[c+2], pad_mid[c]};
        assign o_cells[c] = cell_next(pad_mid[c+1], nbrs) & i_mask[c];
    end

endmodule

FILE: sv/lgrs_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgrs_window
// Three-row window and the job register feeding the evolve logic.
// ----------------------------------------------------------------------------
module lgrs_window
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_xfer,
    input  logic [MAX_WIDTH-1:0] i_row,
    input  logic                 i_last,
    input  logic [MAX_WIDTH-1:0] i_mask,
    input  logic                 i_adv,
    output t_job_ctrl            o_job,
    output logic [MAX_WIDTH-1:0] o_up,
    output logic [MAX_WIDTH-1:0] o_mid,
    output logic [MAX_WIDTH-1:0] o_dn
);

    logic [MAX_WIDTH-1:0] r_above,  n_above;
    logic [MAX_WIDTH-1:0] r_middle, n_middle;
    logic                 r_seen,   n_seen;
    t_job_ctrl            r_job,    n_job;
    logic [MAX_WIDTH-1:0] r_j_up,   n_j_up;
    logic [MAX_WIDTH-1:0] r_j_mid,  n_j_mid;
    logic [MAX_WIDTH-1:0] r_j_dn,   n_j_dn;
    logic [MAX_WIDTH-1:0] row_m;

    assign row_m = i_row & i_mask;

    always_comb begin
        n_above  = r_above;
        n_middle = r_middle;
        n_seen   = r_seen;
        n_job    = r_job;
        n_j_up   = r_j_up;
        n_j_mid  = r_j_mid;
        n_j_dn   = r_j_dn;

        if (i_adv) begin
            if (r_job.pend2) begin
                // last row's own generation: window slides down onto dead row
                n_j_up     = r_j_mid;
                n_j_mid    = r_j_dn;
                n_j_dn     = '0;
                n_job.pend2 = 1'b0;
                n_job.done  = 1'b1;
            end else begin
                n_job.valid = 1'b0;
            end
        end

        if (i_in_xfer) begin
            if (r_seen) begin
                n_j_up      = r_above;
                n_j_mid     = r_middle;
                n_j_dn      = row_m;
                n_job.valid = 1'b1;
                n_job.pend2 = i_last;
                n_job.done  = 1'b0;
                n_above     = r_middle;
            end else begin
                if (i_last) begin
                    n_j_up      = '0;
                    n_j_mid     = row_m;
                    n_j_dn      = '0;
                    n_job.valid = 1'b1;
                    n_job.pend2 = 1'b0;
                    n_job.done  = 1'b1;
                end
                n_above = '0;
            end
            n_middle = row_m;
            n_seen   = ~i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_job  <= '0;
        end else begin
            r_seen <= n_seen;
            r_job  <= n_job;
        end
        r_above  <= n_above;
        r_middle <= n_middle;
        r_j_up   <= n_j_up;
        r_j_mid  <= n_j_mid;
        r_j_dn   <= n_j_dn;
    end

    assign o_job = r_job;
    assign o_up  = r_j_up;
    assign o_mid = r_j_mid;
    assign o_dn  = r_j_dn;

endmodule
